[src/rational_number_alu_top_macros.svh]
// Assertion macros for the rational ALU.
`ifndef RATIONAL_NUMBER_ALU_TOP_MACROS_SVH
`define RATIONAL_NUMBER_ALU_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RNA_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define RNA_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define RNA_ASSERT_IMP(label, clk, rst, a, c)
`define RNA_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

[src/rna_pkg.sv]
// ----------------------------------------------------------------------------
// rna_pkg
// Shared types and codes of the rational ALU.
// ----------------------------------------------------------------------------
package rna_pkg;
  localparam logic [2:0] K_CREATE = 3'd0;
  localparam logic [2:0] K_ADD    = 3'd1;
  localparam logic [2:0] K_SUB    = 3'd2;
  localparam logic [2:0] K_MUL    = 3'd3;
  localparam logic [2:0] K_DIV    = 3'd4;
  localparam logic [2:0] K_CMP    = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL0, OP_MUL1, OP_MUL2, OP_ADD, OP_GCD_INIT, OP_MOD_STEP,
    OP_GCD_SWAP, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_NEXT, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;  // shift/subtract loop finished its bits
    logic y_zero;    // gcd remainder is zero
    logic skip;      // result already decided at load
    logic is_add;    // add or subtract needs the cross sum
  } sts_t;
endpackage

[src/rational_number_alu_top.sv]
// ----------------------------------------------------------------------------
// rational_number_alu_top
// Exact fraction arithmetic with gcd reduction.
// ----------------------------------------------------------------------------
// One item at a time. Compare and errors found at load go straight to the output;
// other kinds run the Euclidean gcd, each remainder step on a 64-bit
// shift/subtract unit, then two exact 64-bit divisions by the gcd, first of the
// numerator and then of the denominator.
`include "rational_number_alu_top_macros.svh"
module rational_number_alu_top #(
  parameter int WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // a_num, a_den, b_num, b_den
  input  logic [2:0]   s_tuser,  // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // res_num, res_den
  output logic [3:0]   m_tuser   // order, status
);
  rna_pkg::cmd_t cmd;
  rna_pkg::sts_t sts;
  logic busy, done, in_fire, out_fire;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0] order, status;

  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign m_tvalid = done;
  assign m_tdata  = {1'b0, res_den, res_num};
  assign m_tuser  = {status, order};

  rna_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .cmd(cmd), .busy(busy), .done(done)
  );

  rna_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .cmd(cmd), .kind(s_tuser),
    .a_num(s_tdata[31:0]), .a_den(s_tdata[63:32]),
    .b_num(s_tdata[95:64]), .b_den(s_tdata[127:96]),
    .sts(sts), .res_num(res_num), .res_den(res_den),
    .order(order), .status(status)
  );

  `RNA_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `RNA_ASSERT_IMP(a_noacc, clk, rst, m_tvalid, !s_tready)
  `RNA_ASSERT_IMP(a_errz, clk, rst, m_tvalid && m_tuser[3:2] != rna_pkg::ST_OK, m_tdata == 64'd0)
endmodule

[src/rna_datapath.sv]
// ----------------------------------------------------------------------------
// rna_datapath
// Cross products, gcd by restoring remainder steps and exact division.
// ----------------------------------------------------------------------------
module rna_datapath #(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  rna_pkg::cmd_t     cmd,
  input  logic [2:0]        kind,
  input  logic [31:0]       a_num,
  input  logic [31:0]       a_den,
  input  logic [31:0]       b_num,
  input  logic [31:0]       b_den,
  output rna_pkg::sts_t     sts,
  output logic [31:0]       res_num,
  output logic [30:0]       res_den,
  output logic [1:0]        order,
  output logic [1:0]        status
);
  localparam int LB = (WIDTH < 32) ? WIDTH : 32;
  localparam logic [63:0] MAXPOS = (64'd1 << (LB - 1)) - 64'd1;

  logic [2:0]  k;
  logic        an_s, ad_s, bn_s, bd_s;
  logic [31:0] an, ad, bn, bd;
  logic [63:0] p0, p1, p2;      // an*bd, bn*ad, ad*bd (ad*bn for divide, ad for create)
  logic        s0, s1, s2;
  logic [63:0] nm, dm;          // magnitudes to reduce
  logic        neg;
  logic [63:0] gx, gy, rem;     // gcd operands and running remainder
  logic [6:0]  cnt;
  logic [63:0] q, r, dv;        // division quotient, remainder, dividend
  logic [63:0] nq;

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  logic [64:0] rsh;
  always_comb begin
    rsh = {r, dv[63]};
    if (rsh >= {1'b0, gx}) rsh = rsh - {1'b0, gx};
  end
  logic [64:0] msh;
  always_comb begin
    msh = {rem, gx[63]};
    if (msh >= {1'b0, gy}) msh = msh - {1'b0, gy};
  end

  assign sts.div_done = (cnt == 7'd64);
  assign sts.y_zero   = (gy == 64'd0);
  assign sts.is_add   = (k == rna_pkg::K_ADD) || (k == rna_pkg::K_SUB);
  assign sts.skip     = (status != rna_pkg::ST_OK) || (k > rna_pkg::K_CMP) ||
                        (k == rna_pkg::K_CMP);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rna_pkg::OP_LOAD: begin
        k <= kind;
        an <= mag(a_num); ad <= mag(a_den); bn <= mag(b_num); bd <= mag(b_den);
        an_s <= a_num[31]; ad_s <= a_den[31]; bn_s <= b_num[31]; bd_s <= b_den[31];
        res_num <= '0; res_den <= '0; order <= '0; status <= rna_pkg::ST_OK;
        if (kind == rna_pkg::K_DIV && b_num == 32'd0) status <= rna_pkg::ST_DIVZ;
      end
      rna_pkg::OP_MUL0: begin
        p0 <= {32'd0, an} * {32'd0, bd}; s0 <= an_s ^ bd_s;
      end
      rna_pkg::OP_MUL1: begin
        p1 <= {32'd0, bn} * {32'd0, ad};
        s1 <= bn_s ^ ad_s ^ (k == rna_pkg::K_SUB);
      end
      rna_pkg::OP_MUL2: begin
        unique case (k)
          rna_pkg::K_CREATE: begin
            nm <= {32'd0, an}; s0 <= an_s; p2 <= {32'd0, ad}; s2 <= ad_s;
          end
          rna_pkg::K_MUL: begin
            nm <= {32'd0, an} * {32'd0, bn}; s0 <= an_s ^ bn_s;
            p2 <= {32'd0, ad} * {32'd0, bd}; s2 <= ad_s ^ bd_s;
          end
          rna_pkg::K_DIV: begin
            nm <= p0; p2 <= {32'd0, ad} * {32'd0, bn}; s2 <= ad_s ^ bn_s;
          end
          rna_pkg::K_CMP: begin
            // Both products stay below 2^63, so their signed forms fit 64 bits.
            if ($signed(s0 ? (64'd0 - p0) : p0) > $signed(s1 ? (64'd0 - p1) : p1))
              order <= 2'b01;
            else if ($signed(s0 ? (64'd0 - p0) : p0) < $signed(s1 ? (64'd0 - p1) : p1))
              order <= 2'b11;
          end
          default: begin
            nm <= p0; p2 <= {32'd0, ad} * {32'd0, bd}; s2 <= ad_s ^ bd_s;
          end
        endcase
      end
      rna_pkg::OP_ADD: begin
        if (s0 == s1) nm <= p0 + p1;
        else if (p0 >= p1) nm <= p0 - p1;
        else begin nm <= p1 - p0; s0 <= s1; end
      end
      rna_pkg::OP_GCD_INIT: begin
        dm <= p2;
        neg <= (nm != 64'd0) && (s0 != s2);
        if (p2 == 64'd0) status <= rna_pkg::ST_DIVZ;
        gx <= nm; gy <= p2; rem <= '0; cnt <= '0;
      end
      rna_pkg::OP_MOD_STEP: begin
        rem <= msh[63:0]; gx <= {gx[62:0], 1'b0}; cnt <= cnt + 7'd1;
      end
      rna_pkg::OP_GCD_SWAP: begin
        gx <= gy; gy <= rem; rem <= '0; cnt <= '0;
      end
      rna_pkg::OP_DIV_INIT: begin
        dv <= nm; r <= '0; q <= '0; cnt <= '0;
      end
      rna_pkg::OP_DIV_STEP: begin
        r <= rsh[63:0]; dv <= {dv[62:0], 1'b0};
        q <= {q[62:0], (({r, dv[63]}) >= {1'b0, gx})};
        cnt <= cnt + 7'd1;
      end
      rna_pkg::OP_DIV_NEXT: begin
        nq <= q; dv <= dm; r <= '0; q <= '0; cnt <= '0;
      end
      rna_pkg::OP_FINISH: begin
        if (status == rna_pkg::ST_OK) begin
          if (q > MAXPOS || (neg ? (nq > MAXPOS + 64'd1) : (nq > MAXPOS)))
            status <= rna_pkg::ST_OVF;
          else begin
            res_num <= neg ? (32'd0 - nq[31:0]) : nq[31:0];
            res_den <= q[30:0];
          end
        end
      end
      default: ;
    endcase
  end
endmodule

[src/rna_ctrl.sv]
// ----------------------------------------------------------------------------
// rna_ctrl
// Sequencer for load, products, gcd loop, two divisions and hand-over.
// ----------------------------------------------------------------------------
module rna_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic          out_fire,
  input  rna_pkg::sts_t sts,
  output rna_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);
  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_ADD, S_GI, S_MOD, S_SWAP, S_DI, S_DS1,
    S_DN, S_DS2, S_FIN, S_OUT
  } state_t;
  state_t state;

  always_comb begin
    cmd.op = rna_pkg::OP_NONE;
    unique case (state)
      S_IDLE: if (in_fire) cmd.op = rna_pkg::OP_LOAD;
      S_M0:   cmd.op = rna_pkg::OP_MUL0;
      S_M1:   cmd.op = rna_pkg::OP_MUL1;
      S_M2:   cmd.op = rna_pkg::OP_MUL2;
      S_ADD:  cmd.op = rna_pkg::OP_ADD;
      S_GI:   cmd.op = rna_pkg::OP_GCD_INIT;
      S_MOD:  cmd.op = sts.div_done ? rna_pkg::OP_GCD_SWAP : rna_pkg::OP_MOD_STEP;
      S_SWAP: cmd.op = rna_pkg::OP_NONE;
      S_DI:   cmd.op = rna_pkg::OP_DIV_INIT;
      S_DS1, S_DS2: cmd.op = sts.div_done ? rna_pkg::OP_NONE : rna_pkg::OP_DIV_STEP;
      S_DN:   cmd.op = rna_pkg::OP_DIV_NEXT;
      S_FIN:  cmd.op = rna_pkg::OP_FINISH;
      default: cmd.op = rna_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; done <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) state <= S_M0;
        S_M0:   state <= S_M1;
        S_M1:   state <= S_M2;
        S_M2:   state <= sts.skip ? S_OUT : (sts.is_add ? S_ADD : S_GI);
        S_ADD:  state <= S_GI;
        S_GI:   state <= S_SWAP;
        // S_SWAP tests the divisor; S_MOD runs one remainder.
        S_SWAP: state <= sts.y_zero ? S_DI : S_MOD;
        S_MOD:  if (sts.div_done) state <= S_SWAP;
        S_DI:   state <= S_DS1;
        S_DS1:  if (sts.div_done) state <= S_DN;
        S_DN:   state <= S_DS2;
        S_DS2:  if (sts.div_done) state <= S_FIN;
        S_FIN:  state <= S_OUT;
        S_OUT:  if (out_fire) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      done <= (state == S_FIN) || (state == S_M2 && sts.skip) ||
              (done && !out_fire);
    end
  end
  assign busy = (state != S_IDLE);
endmodule

[dv/rational_number_alu_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_number_alu_checker
// Watches both streams of the rational ALU, works out the reduced fraction,
// order and status of every accepted item, and compares each result in turn.
// ----------------------------------------------------------------------------
module rational_number_alu_checker #(
  parameter int WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic [3:0]   m_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  order;
    logic [1:0]  status;
  } fraction_result_t;

  typedef struct {
    logic        neg;
    logic [63:0] mag;
  } signed_mag_t;

  fraction_result_t results_due[$];

  function automatic signed_mag_t split_sign(logic [31:0] raw);
    signed_mag_t v;
    v.neg = raw[31];
    v.mag = raw[31] ? {32'd0, -raw} : {32'd0, raw};
    return v;
  endfunction

  function automatic signed_mag_t times(signed_mag_t x, signed_mag_t y);
    signed_mag_t r;
    r.mag = x.mag * y.mag;
    r.neg = (r.mag != 0) && (x.neg != y.neg);
    return r;
  endfunction

  function automatic signed_mag_t plus(signed_mag_t x, signed_mag_t y);
    signed_mag_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic longint as_int(signed_mag_t x);
    return x.neg ? -longint'(x.mag) : longint'(x.mag);
  endfunction

  // Reduces num/den into res; answers the status.
  function automatic logic [1:0] reduce(signed_mag_t num, signed_mag_t den,
                                        inout fraction_result_t res);
    int          lb;
    logic [63:0] maxpos, x, y, t, n, d;
    logic        neg;
    lb = (WIDTH < 32) ? WIDTH : 32;
    maxpos = (64'd1 << (lb - 1)) - 1;
    if (den.mag == 0) return rna_pkg::ST_DIVZ;
    neg = (num.mag != 0) && (num.neg != den.neg);
    x = num.mag;
    y = den.mag;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    n = num.mag / x;
    d = den.mag / x;
    if (d > maxpos) return rna_pkg::ST_OVF;
    if (neg ? (n > maxpos + 1) : (n > maxpos)) return rna_pkg::ST_OVF;
    res.num = neg ? -n[31:0] : n[31:0];
    res.den = d[30:0];
    return rna_pkg::ST_OK;
  endfunction

  function automatic fraction_result_t fraction_outcome(logic [2:0] kind,
                                                        logic [127:0] data);
    fraction_result_t res;
    signed_mag_t      an, ad, bn, bd, t;
    logic [1:0]       st;
    longint           lhs, rhs;
    res = '0;
    st = rna_pkg::ST_OK;
    an = split_sign(data[31:0]);
    ad = split_sign(data[63:32]);
    bn = split_sign(data[95:64]);
    bd = split_sign(data[127:96]);
    case (kind)
      rna_pkg::K_CREATE: st = reduce(an, ad, res);
      rna_pkg::K_ADD, rna_pkg::K_SUB: begin
        t = times(bn, ad);
        if (kind == rna_pkg::K_SUB && t.mag != 0) t.neg = !t.neg;
        st = reduce(plus(times(an, bd), t), times(ad, bd), res);
      end
      rna_pkg::K_MUL: st = reduce(times(an, bn), times(ad, bd), res);
      rna_pkg::K_DIV: begin
        if (bn.mag == 0) st = rna_pkg::ST_DIVZ;
        else st = reduce(times(an, bd), times(ad, bn), res);
      end
      rna_pkg::K_CMP: begin
        lhs = as_int(times(an, bd));
        rhs = as_int(times(bn, ad));
        if (lhs > rhs) res.order = 2'd1;
        else if (lhs < rhs) res.order = 2'd3;
      end
      default: ;
    endcase
    if (st != rna_pkg::ST_OK) begin
      res.num = '0;
      res.den = '0;
    end
    res.status = st;
    return res;
  endfunction

  assign pending = results_due.size();

  always @(posedge clk) begin
    fraction_result_t want, got;
    if (rst) begin
      results_due.delete();
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) results_due.push_back(fraction_outcome(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[62:32], m_tuser[1:0], m_tuser[3:2]};
        if (results_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h", m_tdata);
        end else begin
          want = results_due.pop_front();
          if (got !== want || m_tdata[63] !== 1'b0) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: num %h/%h den %h/%h order %h/%h status %h/%h",
                       want.num, got.num, want.den, got.den, want.order, got.order,
                       want.status, got.status);
          end
        end
      end
    end
  end

endmodule

[dv/rational_number_alu_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_number_alu_top_tb
// Drives directed and random fraction operations with random gaps on both
// streams; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module rational_number_alu_top_tb;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;
  logic [3:0]   m_tuser;
  int           fail_count;
  int           pending;
  int           send_idle_pct;
  int           recv_idle_pct;

  rational_number_alu_top uut (.*);
  rational_number_alu_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("rational_number_alu_top_tb NOT OK");
    $finish;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return 32'(int'($urandom_range(20)) - 10);
      4: return 32'(int'($urandom_range(2000)) - 1000);
      5: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // The item stays valid until the next one or an idle cycle replaces it.
  task automatic send_op(logic [2:0] kind, logic [31:0] an, logic [31:0] ad,
                         logic [31:0] bn, logic [31:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {bd, bn, ad, an};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [2:0] kinds[6];
    kinds = '{rna_pkg::K_CREATE, rna_pkg::K_ADD, rna_pkg::K_SUB, rna_pkg::K_MUL,
              rna_pkg::K_DIV, rna_pkg::K_CMP};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = rna_pkg::K_CREATE;
    send_idle_pct = 13;
    recv_idle_pct = 51;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero denominators, divide by zero, extremes, overflow and unknown kinds.
    send_op(rna_pkg::K_CREATE, 32'd6, 32'd4, 0, 0);
    send_op(rna_pkg::K_CREATE, 32'd5, 32'd0, 0, 0);
    send_op(rna_pkg::K_CREATE, 32'd0, 32'hFFFF_FFF9, 0, 0);
    send_op(rna_pkg::K_CREATE, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
    send_op(rna_pkg::K_CREATE, 32'h8000_0000, 32'd1, 0, 0);
    send_op(rna_pkg::K_CREATE, 32'd3, 32'h8000_0000, 0, 0);
    send_op(rna_pkg::K_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_op(rna_pkg::K_ADD, 32'd1, 32'd0, 32'd1, 32'd3);
    send_op(rna_pkg::K_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
    send_op(rna_pkg::K_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_op(rna_pkg::K_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(rna_pkg::K_MUL, 32'hFFFF_FFFE, 32'd3, 32'd9, 32'hFFFF_FFFA);
    send_op(rna_pkg::K_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    send_op(rna_pkg::K_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
    send_op(rna_pkg::K_DIV, 32'd3, 32'd4, 32'hFFFF_FFFF, 32'd5);
    send_op(rna_pkg::K_DIV, 32'd1, 32'd0, 32'd1, 32'd1);
    send_op(rna_pkg::K_CMP, 32'd1, 32'd2, 32'd1, 32'd3);
    send_op(rna_pkg::K_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
    send_op(rna_pkg::K_CMP, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'd1);
    send_op(rna_pkg::K_CMP, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(rna_pkg::K_CMP, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1);
    send_op(rna_pkg::K_CMP, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd1);
    send_op(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(3'd7, 32'd1, 32'd1, 32'd1, 32'd1);

    for (int i = 0; i < 400; i++) begin
      if (i == 130) begin
        send_idle_pct = 51;
        recv_idle_pct = 13;
      end else if (i == 260) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_op(($urandom_range(39) == 0) ? 3'($urandom_range(7, 6)) : kinds[$urandom_range(5)],
              pick_value(), pick_value(), pick_value(), pick_value());
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (fail_count == 0) begin
      $display("rational_number_alu_top_tb OK");
    end else begin
      $display("rational_number_alu_top_tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/rna_pkg.sv
src/rna_datapath.sv
src/rna_ctrl.sv
src/rational_number_alu_top.sv
dv/rational_number_alu_checker.sv
dv/rational_number_alu_top_tb.sv
